/* sv/sorted_event_priority_queue_core_assert.svh */
// ----------------------------------------------------------------------------
// Sorted event priority queue: assertion macros
// Concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_EVENT_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_EVENT_PRIORITY_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// check prop at every clock edge outside reset
`define SEPQ_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop at every clock edge, reset included
`define SEPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SEPQ_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define SEPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* sv/sepq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted event priority queue package
// Entry layout, command codes and the memory request group.
// ----------------------------------------------------------------------------
`default_nettype none

package sepq_pkg;

	localparam int TIME_W = 32;
	localparam int TAG_W  = 16;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] ev_time;
		logic [TAG_W-1:0]  ev_tag;
		logic              ev_kind;
	} entry_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_req_t;

endpackage

`default_nettype wire

/* sv/sorted_event_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// Sorted event priority queue core
// Bounded sorted list of timed events, smallest time at the front.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; every command gives
// one result word on the cycle done is high, and the receiver cannot stall it.
// A remove or a refused insert goes straight to the fetch of the front entry;
// an insert walks from the front of the list, and each held entry with a
// smaller time moves up one slot until a held entry that is not earlier is
// met, or every held entry has moved and the new one lands at the back.
// Each moved entry costs a read and a compare-and-write through the single
// read port of the entry memory and the one time comparator. Among equal
// times the newest entry is served first.
`default_nettype none

`include "sorted_event_priority_queue_core_assert.svh"

module sorted_event_priority_queue_core #(
	parameter int CAPACITY = 128
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         cmd,
	input  wire  [31:0] event_time,
	input  wire  [15:0] event_tag,
	input  wire         event_kind,
	output logic        done,
	output logic        accepted,
	output logic        queue_empty,
	output logic        queue_full,
	output logic [7:0]  entry_count,
	output logic [31:0] front_time,
	output logic [15:0] front_tag,
	output logic        front_kind
);
	import sepq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_CMP  = 5'b00100,
		S_FRD  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic             ok_q, ok_d;
	entry_t           new_q, new_d;

	mem_req_t         req;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;
	entry_t           wr_data;
	entry_t           rd_data;
	logic [CNT_W-1:0] pos_m1;
	logic [CNT_W-1:0] cnt_m1;
	logic             move_up;

	sepq_store #(
		.DEPTH(CAPACITY)
	) u_store (
		.clk    (clk),
		.req    (req),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign pos_m1  = pos_q - ONE_C;
	assign cnt_m1  = count_q - ONE_C;
	// shared comparator: held entry moves up when strictly earlier
	assign move_up = rd_data.ev_time < new_q.ev_time;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		pos_d   = pos_q;
		ok_d    = ok_q;
		new_d   = new_q;
		req     = '0;
		wr_addr = pos_q[IDX_W-1:0];
		wr_data = new_q;
		rd_addr = pos_m1[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					new_d = '{ev_time: event_time, ev_tag: event_tag, ev_kind: event_kind};
					if (cmd == CMD_INSERT) begin
						ok_d    = (count_q != CAP_C);
						pos_d   = count_q;
						state_d = (count_q != CAP_C) ? S_RD : S_FRD;
					end else begin
						ok_d = (count_q != '0);
						if (count_q != '0) begin
							count_d = cnt_m1;
						end
						state_d = S_FRD;
					end
				end
			end
			S_RD: begin
				if (pos_q == '0) begin
					req.wr_en = 1'b1;
					count_d   = count_q + ONE_C;
					state_d   = S_FRD;
				end else begin
					req.rd_en = 1'b1;
					state_d   = S_CMP;
				end
			end
			S_CMP: begin
				req.wr_en = 1'b1;
				if (move_up) begin
					wr_data = rd_data;
					pos_d   = pos_m1;
					state_d = S_RD;
				end else begin
					count_d = count_q + ONE_C;
					state_d = S_FRD;
				end
			end
			S_FRD: begin
				// fetch the front entry after the update
				req.rd_en = 1'b1;
				rd_addr   = cnt_m1[IDX_W-1:0];
				state_d   = S_OUT;
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pos_q   <= '0;
			ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pos_q   <= pos_d;
			ok_q    <= ok_d;
		end
	end

	always_ff @(posedge clk) begin
		new_q <= new_d;
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_OUT);
	assign accepted    = ok_q;
	assign queue_empty = (count_q == '0);
	assign queue_full  = (count_q == CAP_C);
	assign entry_count = 8'(count_q);
	assign front_time  = (count_q == '0) ? '0 : rd_data.ev_time;
	assign front_tag   = (count_q == '0) ? '0 : rd_data.ev_tag;
	assign front_kind  = (count_q == '0) ? 1'b0 : rd_data.ev_kind;

	`SEPQ_ASSERT_ALWAYS(a_count_bound, clk, !arst_n || count_q <= CAP_C, "count above capacity")
	`SEPQ_ASSERT_RST(a_start_busy, clk, arst_n, (start && !busy) |=> busy, "command not taken")
	`SEPQ_ASSERT_RST(a_done_idle, clk, arst_n, done |=> !busy, "result not followed by idle")
	`SEPQ_ASSERT_RST(a_cmp_pos, clk, arst_n,
		(state_q == S_CMP) |-> (pos_q != '0 && pos_q <= count_q && count_q != CAP_C),
		"shift position out of range")

endmodule

`default_nettype wire

/* sv/sepq_store.sv */
// ----------------------------------------------------------------------------
// Sorted event priority queue: entry store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sepq_store #(
	parameter int DEPTH = 128
) (
	input  wire                        clk,
	input  sepq_pkg::mem_req_t         req,
	input  wire  [$clog2(DEPTH)-1:0]   wr_addr,
	input  sepq_pkg::entry_t           wr_data,
	input  wire  [$clog2(DEPTH)-1:0]   rd_addr,
	output sepq_pkg::entry_t           rd_data
);
	import sepq_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire
